// ===== rtl/core/skl_pkg.sv =====
// Shared constants, types and control encodings for the k-th largest tracker.
package skl_pkg;

  localparam int MAX_RANK = 64;
  localparam int DATA_W   = 32;
  localparam int RANK_W   = 7;
  localparam int CNT_W    = $clog2(MAX_RANK + 1);
  localparam int ADDR_W   = $clog2(MAX_RANK);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_CMP,
    ST_PUT,
    ST_FIND,
    ST_OUT
  } skl_state_t;

  typedef struct packed {
    logic load;      // take the accepted transaction into the datapath
    logic scan_rd;   // address the entry just above the insertion slot
    logic shift_wr;  // move the entry down one slot and step the slot up
    logic put_wr;    // write the new value into the insertion slot
    logic out_load;  // load the result register
  } skl_cmd_t;

  typedef struct packed {
    logic slot_zero;  // insertion slot is the head of the list
    logic slot_one;   // insertion slot is the entry right after the head
    logic less;       // entry read back is smaller than the new value
    logic out_free;   // result register can take a new result
  } skl_status_t;

endpackage

// ===== rtl/core/skl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module skl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/skl_dp.sv =====
// Datapath: sorted value store, insertion slot, count, rank register and result register.
module skl_dp import skl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  skl_cmd_t                 cmd,
  output skl_status_t              status,
  input  logic                     cfg_wr_en,
  input  logic [RANK_W-1:0]        cfg_wr_data,
  input  logic                     in_restart,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic signed [DATA_W-1:0] out_kth_value,
  output logic                     out_found
);

  logic [RANK_W-1:0]        rank_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         slot_r, slot_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_kth_r;
  logic                     out_found_r;

  logic [CNT_W-1:0]         count_base;
  logic [CNT_W-1:0]         k_eff;
  logic [CNT_W-1:0]         slot_m1;
  logic [CNT_W-1:0]         k_m1;
  logic                     slot_in_range;
  logic                     found;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;

  // Rank zero reads as one; ranks past the store depth read as the depth.
  always_comb begin
    if (rank_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(rank_r) > MAX_RANK) begin
      k_eff = CNT_W'(MAX_RANK);
    end else begin
      k_eff = CNT_W'(rank_r);
    end
  end

  assign count_base    = in_restart ? '0 : count_r;
  assign slot_m1       = slot_r - CNT_W'(1);
  assign k_m1          = k_eff - CNT_W'(1);
  assign slot_in_range = (int'(slot_r) < MAX_RANK);
  assign found         = (count_r >= k_eff);

  // The read port points at the reported entry except while scanning, so the
  // read data stays valid while a finished result waits for the output.
  assign ram_raddr = cmd.scan_rd ? slot_m1[ADDR_W-1:0] : k_m1[ADDR_W-1:0];
  assign ram_waddr = slot_r[ADDR_W-1:0];
  assign ram_wdata = cmd.shift_wr ? ram_rdata : value_r;
  // A write into the slot past the last entry is the smallest value falling off.
  assign ram_we    = (cmd.shift_wr || cmd.put_wr) && slot_in_range;

  skl_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_RANK)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    slot_nxt  = slot_r;
    if (cmd.load) begin
      count_nxt = count_base;
      slot_nxt  = count_base;
    end else if (cmd.shift_wr) begin
      slot_nxt = slot_m1;
    end else if (cmd.put_wr && (int'(count_r) < MAX_RANK)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r      <= RANK_W'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rank_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (cmd.load) begin
      value_r <= in_value;
    end
    if (cmd.out_load) begin
      out_found_r <= found;
      out_kth_r   <= found ? $signed(ram_rdata) : '0;
    end
  end

  assign status.slot_zero = (slot_r == '0);
  assign status.slot_one  = (slot_r == CNT_W'(1));
  assign status.less      = ($signed(ram_rdata) < value_r);
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid    = out_valid_r;
  assign out_kth_value = out_kth_r;
  assign out_found     = out_found_r;

endmodule

// ===== rtl/core/skl_ctrl.sv =====
// Controller: sequences the insertion scan, the result read and the output load.
module skl_ctrl import skl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  skl_status_t status,
  output skl_cmd_t    cmd
);

  skl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = status.slot_zero ? ST_PUT : ST_READ;
      end
      ST_READ: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        // Smaller entries move down one place; the first entry that is not
        // smaller marks where the new value goes.
        if (status.less) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = status.slot_one ? ST_PUT : ST_READ;
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd.put_wr = 1'b1;
        state_nxt  = ST_FIND;
      end
      ST_FIND: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/streaming_kth_largest.sv =====
// Top level of the streaming k-th largest value tracker.
// Each input transaction carries one signed 32-bit value and a restart flag;
// each yields one result transaction with the k-th largest value seen since
// the last restart, with found low and the value zero while fewer than k
// values have been seen. The block keeps up to 64 of the largest values in
// descending order in a single-port-read RAM and inserts each new value by
// scanning up from the smallest held entry, reading each entry and then
// comparing it and shifting it down if it is smaller. An accepted item goes
// through start, a read and a compare for each held entry the scan reads
// (those smaller than the new value plus the entry that stops the scan, if
// any; 0 to 64 entries), put, find and the output load, which waits for a
// free output register; one item is worked on at a time. The result sits in
// an output register, so the next item is accepted while a result waits to
// be taken. rank_k is written through cfg_wr_en and cfg_wr_data; 0 acts as 1
// and values above 64 act as 64. No clearing pass follows reset.
module streaming_kth_largest import skl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [RANK_W-1:0] cfg_wr_data,  // rank_k
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,     // [31:0] sample_value
  input  logic              in_tuser,     // [0] restart
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,    // [31:0] kth_value
  output logic              out_tuser     // [0] found
);

  skl_cmd_t                 cmd;
  skl_status_t              status;
  logic signed [DATA_W-1:0] kth_value;

  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  skl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_restart    (in_tuser),
    .in_value      ($signed(in_tdata[DATA_W-1:0])),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_kth_value (kth_value),
    .out_found     (out_tuser)
  );

  assign out_tdata = 32'(kth_value);

endmodule

// ===== rtl/core/skl_checker.sv =====
// Port-level checker for the k-th largest tracker, bound to the top level.
module skl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A result that has not been found always reads as zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("result without found flag carries a nonzero value");

  // Items are worked one at a time, so input is refused right after a transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is still being worked");

  // Nothing comes out of reset as a valid result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed or dropped");

endmodule

bind streaming_kth_largest skl_checker u_skl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming k-th largest value tracker.
module testbench import skl_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 150;
  localparam int PHASE_ITEMS = 580;
  localparam logic [RANK_W-1:0] RANK_TOP = '1;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth_value;
    logic                     found;
  } kth_result_t;

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE, MIX_RISING} value_mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [RANK_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;    // [31:0] sample_value
  logic              in_tuser = 1'b0;  // [0] restart
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;        // [31:0] kth_value
  logic              out_tuser;        // [0] found

  // Shadow of the block: the largest values since restart, largest first.
  logic signed [DATA_W-1:0] held_vals [MAX_RANK];
  int                       held_count = 0;
  logic [RANK_W-1:0]        rank_reg = RANK_W'(1);

  kth_result_t expected_q[$];
  kth_result_t due_result;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  streaming_kth_largest u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Inserts one value into the shadow list and returns the k-th largest.
  function automatic kth_result_t take_sample(bit restart, logic signed [DATA_W-1:0] value);
    int          slot;
    int          last;
    int          k;
    kth_result_t res;
    if (restart) begin
      held_count = 0;
    end
    slot = 0;
    while (slot < held_count && held_vals[slot] >= value) slot++;
    // A full list drops a value that is not above its smallest entry.
    if (slot < MAX_RANK) begin
      last = (held_count < MAX_RANK) ? held_count : MAX_RANK - 1;
      if (held_count < MAX_RANK) begin
        held_count++;
      end
      for (int j = last; j > slot; j--) held_vals[j] = held_vals[j-1];
      held_vals[slot] = value;
    end
    k = int'(rank_reg);
    if (k == 0) k = 1;
    if (k > MAX_RANK) k = MAX_RANK;
    if (held_count >= k) begin
      res.kth_value = held_vals[k-1];
      res.found     = 1'b1;
    end else begin
      res.kth_value = '0;
      res.found     = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample(value_mix_t mix, int idx,
                                                             int base);
    logic signed [DATA_W-1:0] v;
    case (mix)
      MIX_WIDE: begin
        v = $urandom;
      end
      MIX_NARROW: begin
        v = $signed($urandom_range(16)) - 8;
      end
      MIX_EDGE: begin
        case ($urandom_range(5))
          0: v = VAL_MAX;
          1: v = VAL_MAX - 1;
          2: v = VAL_MIN;
          3: v = VAL_MIN + 1;
          4: v = '0;
          default: v = -1;
        endcase
      end
      default: begin
        // A rising run forces the longest insertion scans.
        v = base + idx * 7;
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  task automatic send_sample(bit restart, logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(take_sample(restart, value));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_rank(logic [RANK_W-1:0] value);
    idle_input();
    wait_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rank_reg = value;
    @(posedge clk);
  endtask

  function automatic logic [RANK_W-1:0] pick_rank();
    case ($urandom_range(7))
      0: return '0;
      1: return RANK_W'(1);
      2: return RANK_W'(MAX_RANK);
      3: return RANK_W'(MAX_RANK + 1);
      4: return RANK_TOP;
      default: return RANK_W'($urandom_range(1, MAX_RANK));
    endcase
  endfunction

  // Extremes of the value range and a first value sent without a restart.
  task automatic test_first_values();
    send_sample(1'b0, '0);
    send_sample(1'b0, VAL_MAX);
    send_sample(1'b0, VAL_MIN);
    send_sample(1'b0, -1);
    send_sample(1'b0, 1);
    send_sample(1'b0, VAL_MAX);
    send_sample(1'b1, VAL_MIN);
    send_sample(1'b1, 32'sh5555_AAAA);
  endtask

  // Rank changes mid-stream, rank zero, and ranks beyond the list depth.
  task automatic test_rank_settings();
    set_rank(RANK_W'(2));
    send_sample(1'b1, 5);
    send_sample(1'b0, 5);
    send_sample(1'b0, 3);
    send_sample(1'b0, 7);
    set_rank(RANK_W'(3));
    send_sample(1'b0, 1);
    set_rank('0);
    send_sample(1'b1, -5);
    send_sample(1'b0, 2);
    set_rank(RANK_TOP);
    send_sample(1'b0, 9);
    send_sample(1'b1, 4);
    set_rank(RANK_W'(MAX_RANK));
    send_sample(1'b0, 1);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct);
    int         sent;
    int         len;
    int         base;
    value_mix_t mix;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      set_rank(pick_rank());
      repeat ($urandom_range(2, 4)) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(60, 160);
        mix  = value_mix_t'($urandom_range(3));
        base = $signed($urandom_range(1000)) - 500;
        for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
          send_sample((i == 0) || ($urandom_range(99) == 0), random_sample(mix, i, base));
          sent++;
          if ($urandom_range(199) == 0) begin
            // Hold off until the block has handed back everything.
            idle_input();
            wait_results();
          end
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_values();
    test_rank_settings();
    test_random_traffic(20, 85);
    test_random_traffic(85, 20);
    test_random_traffic(0, 0);
    idle_input();
    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected", '0, out_tdata);
      end else begin
        due_result = expected_q.pop_front();
        if (out_tdata !== due_result.kth_value) begin
          report_mismatch("kth_value", due_result.kth_value, out_tdata);
        end
        if (out_tuser !== due_result.found) begin
          report_mismatch("found", due_result.found, out_tuser);
        end
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
